/* hw/rtl/sctrk_pkg.sv */
// ----------------------------------------------------------------------------
// sctrk_pkg - shared types and constants for the scan code modifier tracker
// Scan code set 1 byte codes, modifier and lock bit positions, state and
// event records passed between the decode stage and the output register.
// ----------------------------------------------------------------------------
package sctrk_pkg;

    // Raw byte codes
    localparam logic [7:0] SC_ESC0   = 8'hE0;
    localparam logic [7:0] SC_ESC1   = 8'hE1;
    localparam logic [7:0] SC_ERR_LO = 8'h00;
    localparam logic [7:0] SC_ERR_HI = 8'hFF;

    // Key codes (release bit removed)
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_ALT    = 7'h38;
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_NUM    = 7'h45;
    localparam logic [6:0] SC_SCROLL = 7'h46;

    localparam int SC_RELEASE_BIT = 7;

    // Held modifier masks
    localparam logic [5:0] MB_LCTRL  = 6'b00_0001;
    localparam logic [5:0] MB_RCTRL  = 6'b00_0010;
    localparam logic [5:0] MB_LALT   = 6'b00_0100;
    localparam logic [5:0] MB_RALT   = 6'b00_1000;
    localparam logic [5:0] MB_LSHIFT = 6'b01_0000;
    localparam logic [5:0] MB_RSHIFT = 6'b10_0000;

    // Lock masks
    localparam logic [2:0] LB_CAPS   = 3'b001;
    localparam logic [2:0] LB_NUM    = 3'b010;
    localparam logic [2:0] LB_SCROLL = 3'b100;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic       esc_e0;
        logic       esc_e1;
        logic [5:0] mods;
        logic [2:0] locks;
    } t_state;

    typedef struct packed {
        logic [2:0] lock_states;
        logic [5:0] held_modifiers;
        logic       prefix_e1;
        logic       prefix_e0;
        logic       released;
        logic [6:0] key_code;
    } t_event;

endpackage

/* hw/rtl/sctrk_decode.sv */
// ----------------------------------------------------------------------------
// sctrk_decode - per-byte decode of scan code set 1
// Computes the next tracker state and the key event, if any, for one byte.
// ----------------------------------------------------------------------------
module sctrk_decode (
    input  logic [7:0]        i_byte,
    input  sctrk_pkg::t_state i_state,
    output sctrk_pkg::t_state o_state,
    output logic              o_emit,
    output sctrk_pkg::t_event o_event
);

    logic       w_up;
    logic [6:0] w_code;
    logic [5:0] w_mask;
    logic       w_held;

    assign w_up   = i_byte[sctrk_pkg::SC_RELEASE_BIT];
    assign w_code = i_byte[6:0];

    // event always reflects the state as it was when the key arrived
    assign o_event.key_code       = w_code;
    assign o_event.released       = w_up;
    assign o_event.prefix_e0      = i_state.esc_e0;
    assign o_event.prefix_e1      = i_state.esc_e1;
    assign o_event.held_modifiers = i_state.mods;
    assign o_event.lock_states    = i_state.locks;

    always_comb begin
        w_mask = '0;
        w_held = 1'b0;
        case (w_code)
            sctrk_pkg::SC_CTRL: begin
                w_mask = i_state.esc_e0 ? sctrk_pkg::MB_RCTRL : sctrk_pkg::MB_LCTRL;
                w_held = 1'b1;
            end
            sctrk_pkg::SC_ALT: begin
                w_mask = i_state.esc_e0 ? sctrk_pkg::MB_RALT : sctrk_pkg::MB_LALT;
                w_held = 1'b1;
            end
            sctrk_pkg::SC_LSHIFT: begin
                w_mask = sctrk_pkg::MB_LSHIFT;
                w_held = 1'b1;
            end
            sctrk_pkg::SC_RSHIFT: begin
                w_mask = sctrk_pkg::MB_RSHIFT;
                w_held = 1'b1;
            end
            default: begin
                w_mask = '0;
                w_held = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        if (i_byte == sctrk_pkg::SC_ESC0) begin
            o_state.esc_e0 = 1'b1;
        end else if (i_byte == sctrk_pkg::SC_ESC1) begin
            o_state.esc_e1 = 1'b1;
        end else if (i_byte == sctrk_pkg::SC_ERR_LO || i_byte == sctrk_pkg::SC_ERR_HI) begin
            o_state = i_state;
        end else begin
            if (w_held) begin
                o_state.mods = w_up ? (i_state.mods & ~w_mask) : (i_state.mods | w_mask);
            end
            case (w_code)
                sctrk_pkg::SC_CTRL, sctrk_pkg::SC_ALT: begin
                    o_state.esc_e0 = 1'b0;
                    o_state.esc_e1 = 1'b0;
                end
                // shift keeps the prefixes
                sctrk_pkg::SC_LSHIFT, sctrk_pkg::SC_RSHIFT: begin
                    o_state.esc_e0 = i_state.esc_e0;
                end
                sctrk_pkg::SC_CAPS: begin
                    if (!w_up) o_state.locks = i_state.locks ^ sctrk_pkg::LB_CAPS;
                end
                sctrk_pkg::SC_NUM: begin
                    if (!w_up) o_state.locks = i_state.locks ^ sctrk_pkg::LB_NUM;
                end
                sctrk_pkg::SC_SCROLL: begin
                    if (!w_up) o_state.locks = i_state.locks ^ sctrk_pkg::LB_SCROLL;
                end
                default: begin
                    o_emit         = 1'b1;
                    o_state.esc_e0 = 1'b0;
                    o_state.esc_e1 = 1'b0;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/sctrk_out_reg.sv */
// ----------------------------------------------------------------------------
// sctrk_out_reg - result register for key events
// Holds one event until the downstream side takes it; reloads in the same
// cycle that the held event leaves.
// ----------------------------------------------------------------------------
module sctrk_out_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  sctrk_pkg::t_event                   i_event,
    output logic                                o_free,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [sctrk_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int EV_W = $bits(sctrk_pkg::t_event);

    logic              r_valid;
    sctrk_pkg::t_event r_event;

    assign o_free     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(sctrk_pkg::OUT_DATA_W - EV_W){1'b0}}, r_event};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_event <= i_event;
        end
    end

endmodule

/* hw/rtl/scancode_modifier_tracker_unit.sv */
// ----------------------------------------------------------------------------
// scancode_modifier_tracker_unit - scan code set 1 modifier tracker
// Decodes raw keyboard bytes, tracks held ctrl/alt/shift and lock toggles,
// and emits one event per ordinary key press or release.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*): one raw scan byte per item, from the keyboard
//   controller. Master channel (o_m_*): one key event per item.
//   E0/E1 escapes, the error bytes 00/FF, modifier keys (ctrl, alt, shift)
//   and lock keys (caps, num, scroll) update internal state only and
//   produce no event. Every other byte produces exactly one event carrying
//   the state as it stood before that byte.
//   Path: an accepted byte sits in the input register; from there its
//   event moves into the result register, which drives o_m_tvalid.
//   Throughput: one byte per cycle unless held back by a stall (below),
//   set by the state update loop in the decode stage.
//   Stall: a full result register that is not taken holds back only bytes
//   that produce events; state-only bytes keep flowing. Once the input
//   register also holds an event byte, o_s_tready drops until the result
//   register drains.
//   Reset (i_rst_n low, synchronous): no modifiers held, all locks off,
//   no prefixes, both registers empty.
// ----------------------------------------------------------------------------
module scancode_modifier_tracker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave: tdata[7:0] scan_byte
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [sctrk_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // master: tdata[6:0] key_code, [7] released, [8] prefix_e0,
    //         [9] prefix_e1, [15:10] held_modifiers, [18:16] lock_states,
    //         [23:19] zero
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [sctrk_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;

    // tracker state
    sctrk_pkg::t_state r_state;
    sctrk_pkg::t_state n_state;

    logic              w_emit;
    sctrk_pkg::t_event w_event;
    logic              w_out_free;
    logic              w_go;

    // the staged byte moves on unless it needs a result slot that is busy
    assign w_go       = r_in_valid && (!w_emit || w_out_free);
    assign o_s_tready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_go) begin
            r_state <= n_state;
        end
    end

    sctrk_decode u_decode (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .o_state (n_state),
        .o_emit  (w_emit),
        .o_event (w_event)
    );

    sctrk_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid && w_emit),
        .i_event    (w_event),
        .o_free     (w_out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // error bytes leave the tracker state untouched
    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_in_byte == sctrk_pkg::SC_ERR_LO || r_in_byte == sctrk_pkg::SC_ERR_HI))
        |=> $stable(r_state))
        else $error("state changed on error byte");

    // prefixes are consumed by every emitted event
    a_emit_clears_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_emit) |=> (!r_state.esc_e0 && !r_state.esc_e1 && o_m_tvalid))
        else $error("event did not clear prefixes or was not registered");

    // a blocked byte stays staged and state waits with it
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_go) |=> (r_in_valid && $stable(r_in_byte) && $stable(r_state)))
        else $error("stalled byte lost or state advanced");

endmodule
